[src/nir_pkg.sv]
// Package for the NEC infrared edge decoder: word types, phase codes and timing constants.
`default_nettype none
package nir_pkg;

	// Event word: edge or timeout tick with its timestamp
	typedef struct packed {
		logic        func;
		logic        line_level;
		logic [31:0] stamp;
	} evt_t;

	// Result word: full code or repeat
	typedef struct packed {
		logic        kind;
		logic [31:0] code;
	} res_t;

	// Frame phase
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_START  = 2'd1,
		PH_BITS   = 2'd2,
		PH_UNUSED = 2'd3
	} phase_t;

	// Event kinds
	localparam logic FUNC_EDGE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Result kinds
	localparam logic KIND_CODE   = 1'b0;
	localparam logic KIND_REPEAT = 1'b1;

	// Register indexes
	localparam logic REG_FRAME_GAP  = 1'b0;
	localparam logic REG_REPEAT_WIN = 1'b1;

	// Register reset values
	localparam logic [15:0] FRAME_GAP_RST  = 16'd30000;
	localparam logic [31:0] REPEAT_WIN_RST = 32'd262144;

	// Timing limits in microseconds
	localparam logic [15:0] RISE_MAX_US     = 16'd11000;
	localparam logic [15:0] TICK_MAX_US     = 16'd10000;
	localparam logic [15:0] MARK_MIN_US     = 16'd300;
	localparam logic [15:0] MARK_MAX_US     = 16'd750;
	localparam logic [15:0] REP_LO_US       = 16'd2000;
	localparam logic [15:0] REP_HI_US       = 16'd2500;
	localparam logic [15:0] LEAD_LO_US      = 16'd4000;
	localparam logic [15:0] LEAD_HI_US      = 16'd5000;
	localparam logic [15:0] BIT_MIN_US      = 16'd400;
	localparam logic [15:0] BIT_MAX_US      = 16'd1880;
	localparam logic [15:0] BIT_HOLE_LO_US  = 16'd800;
	localparam logic [15:0] BIT_HOLE_HI_US  = 16'd1400;
	localparam logic [15:0] BIT_ONE_US      = 16'd1000;

	// Bits in a full code
	localparam logic [5:0] CODE_BITS = 6'd32;

endpackage
`default_nettype wire

[src/nec_ir_edge_decoder_top.sv]
// NEC infrared frame decoder top level: event register, decode logic and result register.
// Path: an accepted word sits in the event register and is decoded into the result register.
// Throughput: one event word per cycle unless results stall; the decode of a registered
// event is one pass of compare logic against the frame state; back-to-back events are taken.
// Reset: line level high, phase idle, bit count, stamps and shift register zero,
// frame gap 30000 us, repeat window 262144 ticks, no word held in either register.
`default_nettype none
module nec_ir_edge_decoder_top
	import nir_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// event channel
	input  wire logic        evt_valid,
	output logic             evt_stall,
	input  wire evt_t        evt_word,
	// result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output res_t             res_word,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// Configuration registers
	logic [15:0] frame_gap_q;
	logic [31:0] repeat_win_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_gap_q  <= FRAME_GAP_RST;
			repeat_win_q <= REPEAT_WIN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_GAP:  frame_gap_q  <= pwdata[15:0];
				REG_REPEAT_WIN: repeat_win_q <= pwdata;
				default:        ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (paddr[2])
			REG_FRAME_GAP:  prdata = {16'd0, frame_gap_q};
			REG_REPEAT_WIN: prdata = repeat_win_q;
			default:        prdata = 32'd0;
		endcase
	end

	// Handshake: the event stage moves on whenever the result register can take a word
	logic valid_s1;
	evt_t evt_s1;
	logic res_valid_q;
	res_t res_q;
	logic res_blocked;

	assign res_blocked = res_valid_q && res_stall;
	assign evt_stall   = valid_s1 && res_blocked;
	assign res_valid   = res_valid_q;
	assign res_word    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!evt_stall) begin
			evt_s1 <= evt_word;
		end
	end

	// Frame state
	logic        last_level_q;
	logic [31:0] last_edge_q;
	phase_t      phase_q;
	logic [5:0]  bit_count_q;
	logic [31:0] shift_q;

	logic        last_level_d;
	logic [31:0] last_edge_d;
	phase_t      phase_d;
	logic [5:0]  bit_count_d;
	logic [31:0] shift_d;
	logic        emit;
	res_t        res_d;
	logic        step;

	assign step = valid_s1 && !res_blocked;

	// Elapsed microseconds since the last edge, 16 bits
	logic [31:0] diff;
	logic [31:0] half_neg;
	logic [31:0] neg_td;
	logic [15:0] td;

	assign diff     = evt_s1.stamp - last_edge_q;
	assign half_neg = (32'd0 - diff) >> 1;
	assign neg_td   = 32'd0 - half_neg;

	always_comb begin
		if (diff[31]) begin
			td = neg_td[15:0];
		end else if (diff[31:17] != 15'd0) begin
			td = 16'hFFFF;
		end else begin
			td = diff[16:1];
		end
	end

	// Repeat window: signed stamp difference below the unsigned window
	logic [31:0] rep_diff;
	logic        in_window;

	assign rep_diff  = evt_s1.stamp - shift_q;
	assign in_window = rep_diff[31] || (rep_diff < repeat_win_q);

	// Timing classes
	logic is_edge;
	logic is_tick;
	logic is_rep_gap;
	logic is_lead_bad;
	logic is_bit_bad;
	logic [5:0] bit_count_inc;

	assign is_tick     = valid_s1 && (evt_s1.func == FUNC_TICK) && (phase_q != PH_IDLE);
	assign is_edge     = valid_s1 && (evt_s1.func == FUNC_EDGE)
	                     && (evt_s1.line_level != last_level_q);
	assign is_rep_gap  = (td > REP_LO_US) && (td < REP_HI_US);
	assign is_lead_bad = (td < LEAD_LO_US) || (td > LEAD_HI_US);
	assign is_bit_bad  = (td < BIT_MIN_US) || (td > BIT_MAX_US)
	                     || ((td > BIT_HOLE_LO_US) && (td < BIT_HOLE_HI_US));
	assign bit_count_inc = bit_count_q + 6'd1;

	// Next state
	always_comb begin
		last_level_d = last_level_q;
		last_edge_d  = last_edge_q;
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		if (is_tick) begin
			if (td > TICK_MAX_US) begin
				phase_d = PH_IDLE;
			end
		end else if (is_edge) begin
			last_level_d = evt_s1.line_level;
			last_edge_d  = evt_s1.stamp;
			if (evt_s1.line_level) begin
				// rise: mark too long, or bad mark while receiving bits
				if (td > RISE_MAX_US) begin
					phase_d = PH_IDLE;
				end else if ((phase_q == PH_BITS)
				             && ((td < MARK_MIN_US) || (td > MARK_MAX_US))) begin
					phase_d = PH_IDLE;
				end
			end else if ((phase_q == PH_IDLE) || (td >= frame_gap_q)) begin
				phase_d     = PH_START;
				bit_count_d = 6'd0;
			end else begin
				unique case (phase_q)
					PH_START: begin
						if (is_rep_gap) begin
							if (in_window) begin
								shift_d = evt_s1.stamp;
							end
						end else if (is_lead_bad) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_BITS;
							shift_d = 32'd0;
						end
					end
					PH_BITS: begin
						if (is_bit_bad) begin
							phase_d = PH_IDLE;
						end else if (!bit_count_q[5]) begin
							bit_count_d = bit_count_inc;
							if (bit_count_inc == CODE_BITS) begin
								shift_d = evt_s1.stamp;
								phase_d = PH_IDLE;
							end else if (td > BIT_ONE_US) begin
								shift_d = shift_q | (32'd1 << bit_count_q[4:0]);
							end
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// Result word
	logic [31:0] code_full;

	assign code_full = (td > BIT_ONE_US) ? (shift_q | (32'd1 << bit_count_q[4:0])) : shift_q;

	always_comb begin
		emit       = 1'b0;
		res_d.kind = KIND_CODE;
		res_d.code = code_full;
		if (is_edge && !evt_s1.line_level && (phase_q != PH_IDLE)
		    && (td < frame_gap_q)) begin
			unique case (phase_q)
				PH_START: begin
					if (is_rep_gap && in_window) begin
						emit       = 1'b1;
						res_d.kind = KIND_REPEAT;
						res_d.code = 32'd0;
					end
				end
				PH_BITS: begin
					emit = !is_bit_bad && !bit_count_q[5] && (bit_count_inc == CODE_BITS);
				end
				default: emit = 1'b0;
			endcase
		end
	end

	// State registers, updated when the event stage moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
			last_edge_q  <= 32'd0;
			phase_q      <= PH_IDLE;
			bit_count_q  <= 6'd0;
			shift_q      <= 32'd0;
		end else if (step) begin
			last_level_q <= last_level_d;
			last_edge_q  <= last_edge_d;
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_blocked) begin
			res_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_blocked) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

[tb/sv/nec_ir_edge_decoder_top_tb.sv]
// Self-checking testbench for the NEC infrared edge decoder: event stimulus, decode predictor, result check.
module nec_ir_edge_decoder_top_tb;
	import nir_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	// Decoder timing limits, microseconds
	localparam logic [15:0] RISE_LIMIT   = 16'd11000;
	localparam logic [15:0] TICK_LIMIT   = 16'd10000;
	localparam logic [15:0] MARK_LO      = 16'd300;
	localparam logic [15:0] MARK_HI      = 16'd750;
	localparam logic [15:0] REPEAT_LO    = 16'd2000;
	localparam logic [15:0] REPEAT_HI    = 16'd2500;
	localparam logic [15:0] LEADER_LO    = 16'd4000;
	localparam logic [15:0] LEADER_HI    = 16'd5000;
	localparam logic [15:0] SPACE_LO     = 16'd400;
	localparam logic [15:0] SPACE_HI     = 16'd1880;
	localparam logic [15:0] HOLE_LO      = 16'd800;
	localparam logic [15:0] HOLE_HI      = 16'd1400;
	localparam logic [15:0] ONE_ABOVE    = 16'd1000;
	localparam logic [5:0]  BITS_PER_CODE = 6'd32;
	localparam logic [15:0] GAP_RESET    = 16'd30000;
	localparam logic [31:0] WIN_RESET    = 32'd262144;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        evt_valid = 1'b0;
	logic        evt_stall;
	evt_t        evt_word = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res_word;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	nec_ir_edge_decoder_top uut (
		.clk(clk), .arst_n(arst_n),
		.evt_valid(evt_valid), .evt_stall(evt_stall), .evt_word(evt_word),
		.res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predicted decoder state and register copy
	logic        line_lvl = 1'b1;
	logic [31:0] edge_stamp = '0;
	phase_t      frame_phase = PH_IDLE;
	logic [5:0]  bit_cnt = '0;
	logic [31:0] shift_stamp = '0;
	logic [15:0] gap_cfg = GAP_RESET;
	logic [31:0] win_cfg = WIN_RESET;

	// Pending event words, expected result words, bookkeeping
	evt_t evt_pend_q[$];
	res_t res_want_q[$];
	int   n_pushed = 0;
	int   n_acc = 0;
	int   n_codes = 0;
	int   n_repeats = 0;
	int   n_err = 0;
	int   n_settings = 0;
	int   n_directed = 0;
	int   quiet_cyc = 0;
	int   snd_idle_pct = 0;
	int   rcv_idle_pct = 0;
	int   tick_pct = 0;

	// Stimulus generator state: line level and clock in half-us ticks
	logic        gen_level = 1'b1;
	logic [31:0] t_now = '0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Microseconds since the last edge: signed wrap difference halved toward zero,
	// positive side saturated, negative side truncated to 16 bits
	function automatic logic [15:0] since_edge_us(logic [31:0] stamp);
		logic [31:0] d;
		logic [31:0] h;
		d = stamp - edge_stamp;
		if (d[31]) begin
			h = (32'd0 - d) >> 1;
			h = 32'd0 - h;
			return h[15:0];
		end
		h = d >> 1;
		return (h > 32'd65535) ? 16'hFFFF : h[15:0];
	endfunction

	// Advance the predicted decoder by one event word, queue any result word
	task automatic decode_event(input evt_t e);
		logic [15:0]       td;
		logic [31:0]       age;
		logic signed [32:0] age_s;
		res_t              r;
		if (e.func == FUNC_TICK) begin
			if (frame_phase != PH_IDLE && since_edge_us(e.stamp) > TICK_LIMIT)
				frame_phase = PH_IDLE;
			return;
		end
		if (e.line_level == line_lvl)
			return;
		line_lvl = e.line_level;
		td = since_edge_us(e.stamp);
		edge_stamp = e.stamp;
		if (e.line_level) begin
			if (td > RISE_LIMIT)
				frame_phase = PH_IDLE;
			if (frame_phase == PH_BITS && (td < MARK_LO || td > MARK_HI))
				frame_phase = PH_IDLE;
		end else if (frame_phase == PH_IDLE || td >= gap_cfg) begin
			frame_phase = PH_START;
			bit_cnt = '0;
		end else if (frame_phase == PH_START) begin
			if (td > REPEAT_LO && td < REPEAT_HI) begin
				age = e.stamp - shift_stamp;
				age_s = {age[31], age};
				if (age_s < $signed({1'b0, win_cfg})) begin
					r.kind = KIND_REPEAT;
					r.code = '0;
					res_want_q.push_back(r);
					shift_stamp = e.stamp;
				end
			end else if (td < LEADER_LO || td > LEADER_HI) begin
				frame_phase = PH_IDLE;
			end else begin
				frame_phase = PH_BITS;
				shift_stamp = '0;
			end
		end else if (frame_phase != PH_BITS) begin
			frame_phase = PH_IDLE;
		end else if (td < SPACE_LO || td > SPACE_HI) begin
			frame_phase = PH_IDLE;
		end else if (td > HOLE_LO && td < HOLE_HI) begin
			frame_phase = PH_IDLE;
		end else if (bit_cnt < BITS_PER_CODE) begin
			if (td > ONE_ABOVE)
				shift_stamp[bit_cnt[4:0]] = 1'b1;
			bit_cnt = bit_cnt + 6'd1;
			if (bit_cnt == BITS_PER_CODE) begin
				r.kind = KIND_CODE;
				r.code = shift_stamp;
				res_want_q.push_back(r);
				shift_stamp = e.stamp;
				frame_phase = PH_IDLE;
			end
		end
	endtask

	// Event driver: predicts each accepted word, then loads the next one
	always @(posedge clk) begin : evt_feed
		evt_t nxt_word;
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = evt_valid;
			nxt_word = evt_word;
			if (evt_valid && !evt_stall) begin
				decode_event(evt_word);
				n_acc++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && evt_pend_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				nxt_word = evt_pend_q.pop_front();
				nxt_valid = 1'b1;
			end
			evt_valid <= nxt_valid;
			evt_word <= nxt_word;
		end
	end

	// Result back-pressure
	always @(posedge clk) begin
		res_stall <= arst_n && ($urandom_range(99) < rcv_idle_pct);
	end

	function automatic void report(string what, logic [31:0] want, logic [31:0] got);
		n_err++;
		if (n_err <= 10)
			$display("result %0s wrong: expected %08h got %08h", what, want, got);
	endfunction

	// Result checker against the oldest expected word
	always @(posedge clk) begin : res_check
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (res_word.kind == KIND_REPEAT)
				n_repeats++;
			else
				n_codes++;
			if (res_want_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("result word with none expected: kind %0d code %08h",
						res_word.kind, res_word.code);
			end else begin
				want = res_want_q.pop_front();
				if (res_word.kind !== want.kind)
					report("kind", {31'd0, want.kind}, {31'd0, res_word.kind});
				if (res_word.code !== want.code)
					report("code", want.code, res_word.code);
			end
		end
	end

	// Watchdog: cycles with work outstanding and no word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_valid && !evt_stall) || (res_valid && !res_stall) ||
				(n_acc == n_pushed && res_want_q.size() == 0)) begin
				quiet_cyc <= 0;
			end else if (quiet_cyc >= WATCHDOG_LIMIT) begin
				$display("stalled for %0d cycles with %0d words unsent, %0d results owed",
					quiet_cyc, n_pushed - n_acc, res_want_q.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cyc <= quiet_cyc + 1;
			end
		end
	end

	// Register write: setup cycle, then access cycle
	task automatic reg_write(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_FRAME_GAP)
			gap_cfg = val[15:0];
		else
			win_cfg = val;
	endtask

	task automatic queue_word(input logic fn, input logic lvl, input logic [31:0] stamp);
		evt_t w;
		while (evt_pend_q.size() >= 24)
			@(posedge clk);
		w.func = fn;
		w.line_level = lvl;
		w.stamp = stamp;
		evt_pend_q.push_back(w);
		n_pushed++;
		if (fn == FUNC_EDGE)
			gen_level = lvl;
	endtask

	// Edge after dur microseconds; now and then a timeout tick slips in first
	task automatic send_edge(input logic lvl, input int unsigned dur);
		if (tick_pct != 0 && $urandom_range(99) < tick_pct)
			queue_word(FUNC_TICK, 1'($urandom_range(1)),
				t_now + $urandom_range(0, ($urandom_range(3) == 0) ? 30000 : 16000));
		t_now = t_now + 2 * dur + $urandom_range(1);
		queue_word(FUNC_EDGE, lvl, t_now);
	endtask

	task automatic raise_line();
		if (!gen_level)
			send_edge(1'b1, $urandom_range(500, 15000));
	endtask

	function automatic int unsigned warp(int idx, int bad_at, int unsigned dur);
		return (idx == bad_at) ? $urandom_range(0, 20000) : dur;
	endfunction

	// Full frame: leader mark and space, 32 bits LSB first, stop mark
	task automatic send_nec_code(input logic [31:0] val, input bit spoil);
		int          bad_at;
		int unsigned lead_gap;
		bad_at = spoil ? $urandom_range(0, 67) : -1;
		lead_gap = ($urandom_range(3) == 0) ? $urandom_range(12000, 70000)
			: $urandom_range(40000, 70000);
		raise_line();
		send_edge(1'b0, warp(0, bad_at, lead_gap));
		send_edge(1'b1, warp(1, bad_at, $urandom_range(8500, 9500)));
		send_edge(1'b0, warp(2, bad_at, $urandom_range(4000, 5000)));
		for (int i = 0; i < 32; i++) begin
			send_edge(1'b1, warp(3 + 2 * i, bad_at, $urandom_range(300, 750)));
			send_edge(1'b0, warp(4 + 2 * i, bad_at,
				val[i] ? $urandom_range(1400, 1880) : $urandom_range(400, 800)));
		end
		send_edge(1'b1, warp(67, bad_at, $urandom_range(300, 750)));
	endtask

	task automatic send_repeat();
		raise_line();
		send_edge(1'b0, $urandom_range(20000, 60000));
		send_edge(1'b1, $urandom_range(8500, 9500));
		send_edge(1'b0, $urandom_range(2001, 2499));
		send_edge(1'b1, $urandom_range(300, 750));
	endtask

	// Junk on the line: random gaps, time running backward, no-change edges, stray ticks
	task automatic send_noise();
		case ($urandom_range(3))
			0: send_edge(!gen_level, $urandom_range(0, 70000));
			1: begin
				t_now = t_now - $urandom_range(1, 200000);
				queue_word(FUNC_EDGE, !gen_level, t_now);
			end
			2: queue_word(FUNC_EDGE, gen_level, t_now + $urandom_range(0, 4000));
			default: begin
				t_now = $urandom();
				queue_word(FUNC_TICK, 1'($urandom_range(1)), t_now);
			end
		endcase
	endtask

	task automatic drain();
		while (n_acc != n_pushed || res_want_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// One register setting: write both registers, then random traffic until enough words are queued
	// and results checked, or six times the word target is queued, then drain
	task automatic run_setting(input logic [15:0] gap, input logic [31:0] win,
		input int n_items, input int n_res);
		int base_items;
		int base_res;
		int pick;
		reg_write(REG_FRAME_GAP, {16'd0, gap});
		reg_write(REG_REPEAT_WIN, win);
		n_settings++;
		base_items = n_pushed;
		base_res = n_codes + n_repeats;
		while ((n_pushed - base_items < n_items || n_codes + n_repeats - base_res < n_res)
			&& n_pushed - base_items < 6 * n_items) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				send_nec_code($urandom(), $urandom_range(9) == 0);
			end else if (pick < 70) begin
				send_repeat();
			end else if (pick < 85) begin
				send_nec_code($urandom(), 1'b0);
				repeat ($urandom_range(1, 3)) send_repeat();
			end else begin
				repeat ($urandom_range(1, 4)) send_noise();
			end
		end
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle tick, no-change edge, start across the stamp wrap, tick timeout,
		// repeat in window, boundary gaps, bad mark, negative and saturated elapsed time
		snd_idle_pct = 8;
		rcv_idle_pct = 47;
		queue_word(FUNC_TICK, 1'b0, 32'hFFFF_FFFF);
		queue_word(FUNC_EDGE, 1'b1, 32'h0000_1234);
		t_now = 32'hFFFF_FFF0;
		send_edge(1'b0, 0);
		send_edge(1'b1, 9000);
		queue_word(FUNC_TICK, 1'b1, t_now + 32'd20004);
		send_edge(1'b0, 50000);
		send_edge(1'b1, 9000);
		send_edge(1'b0, 2250);
		send_edge(1'b1, 560);
		send_edge(1'b0, 2000);
		send_edge(1'b1, 12000);
		send_edge(1'b0, 100);
		send_edge(1'b1, 9000);
		send_edge(1'b0, 4000);
		send_edge(1'b1, 750);
		send_edge(1'b0, 400);
		send_edge(1'b1, 300);
		send_edge(1'b0, 1880);
		send_edge(1'b1, 751);
		t_now = t_now - 32'd1000;
		queue_word(FUNC_EDGE, 1'b0, t_now);
		send_edge(1'b1, 9000);
		send_edge(1'b0, 5000);
		send_edge(1'b1, 500);
		send_edge(1'b0, 1000);
		send_edge(1'b1, 70000);
		n_directed = n_pushed;
		drain();

		// Random part in three idling regimes
		t_now = $urandom();
		tick_pct = 4;
		run_setting(16'hFFFF, 32'hFFFF_FFFF, 160, 3);
		run_setting(16'd0, 32'd0, 60, 0);

		snd_idle_pct = 47;
		rcv_idle_pct = 8;
		run_setting(16'd5001, 32'd100000, 160, 3);
		run_setting(16'd12000, 32'd0, 150, 3);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_setting(GAP_RESET, WIN_RESET, 160, 3);
		run_setting(16'd20000, 32'h7FFF_FFFF, 160, 3);

		drain();
		$display("event words: %0d accepted (%0d directed), %0d register settings",
			n_acc, n_directed, n_settings);
		$display("results checked: %0d full codes, %0d repeats, %0d mismatches",
			n_codes, n_repeats, n_err);
		if (n_err == 0 && res_want_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[files.f]
src/nir_pkg.sv
src/nec_ir_edge_decoder_top.sv
tb/sv/nec_ir_edge_decoder_top_tb.sv
